### rtl/core/qdl_pkg.sv
// ----------------------------------------------------------------------------
// qdl_pkg
// Shared types, constants and fixed-point helpers of the quantized dense
// layer multiply-accumulate block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qdl_pkg;

   localparam int LANES       = 4;
   localparam int NUM_WEIGHTS = 4;
   localparam int ACTIVE_MAX  = (LANES < NUM_WEIGHTS) ? LANES : NUM_WEIGHTS;
   localparam int OUT_SCALE   = 15;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
   localparam int ADDR_W      = 5;

   localparam logic [2:0] ROWS_MAX = 3'(ACTIVE_MAX);

   localparam logic [2:0] REG_KERNEL_FRAC = 3'd0;
   localparam logic [2:0] REG_INPUT_FRAC  = 3'd1;
   localparam logic [2:0] REG_REC_FRAC    = 3'd2;
   localparam logic [2:0] REG_BIAS_FRAC   = 3'd3;
   localparam logic [2:0] REG_BIAS_EN     = 3'd4;
   localparam logic [2:0] REG_REC_EN      = 3'd5;

   typedef logic signed [5:0] shift_type;

   typedef struct packed {
      logic signed [15:0] in_value;
      logic signed [7:0]  weight_0;
      logic signed [7:0]  weight_1;
      logic signed [7:0]  weight_2;
      logic signed [7:0]  weight_3;
      logic signed [15:0] bias_0;
      logic signed [15:0] bias_1;
      logic signed [15:0] bias_2;
      logic signed [15:0] bias_3;
      logic [2:0]         rows_in_group;
      logic               phase_recurrent;
      logic               last_element;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_0;
      logic signed [31:0] result_1;
      logic signed [31:0] result_2;
      logic signed [31:0] result_3;
      logic [2:0]         rows_valid;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             is_final;
      logic             rescale;
      logic [LANES-1:0] active;
      logic [2:0]       rows;
      logic             bias_en;
      shift_type        rescale_shift;
      shift_type        bias_shift;
      shift_type        align_shift;
      shift_type        out_shift;
   } ctl_type;

   // Positive s clamps to the range that survives a left shift by s, then
   // shifts; negative s is an arithmetic right shift.
   function automatic logic signed [31:0] sat_shift(input logic signed [31:0] x,
                                                    input shift_type s);
      logic [5:0]         neg;
      logic [4:0]         amt;
      logic signed [31:0] hi_part;
      logic               ovf;
      logic signed [31:0] r;
      neg     = 6'(-s);
      amt     = s[4:0];
      hi_part = x >>> (5'd31 - amt);
      ovf     = (hi_part != '0) && (hi_part != '1);
      if (s == '0) begin
         r = x;
      end else if (s < 0) begin
         r = x >>> ((neg > 6'd31) ? 5'd31 : neg[4:0]);
      end else if (ovf) begin
         r = x[31] ? 32'sh8000_0000 : $signed((32'h7FFF_FFFF >> amt) << amt);
      end else begin
         r = x <<< amt;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] align_bias(input logic signed [15:0] b,
                                                     input shift_type s);
      logic signed [31:0] bx;
      logic [5:0]         neg;
      logic signed [31:0] r;
      bx  = {{16{b[15]}}, b};
      neg = 6'(-s);
      if (s >= 0) begin
         r = bx <<< s[4:0];
      end else begin
         r = bx >>> ((neg > 6'd31) ? 5'd31 : neg[4:0]);
      end
      return r;
   endfunction

endpackage

### rtl/core/qdl_lane.sv
// ----------------------------------------------------------------------------
// qdl_lane
// One output row: 16x8 product, wrapping 32-bit accumulator with the
// phase-end rescale, and the final align, bias and output rescale stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdl_lane
   import qdl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic signed [15:0] x,
   input  logic signed [7:0]  w,
   input  logic signed [15:0] bias,
   input  ctl_type            s1,
   input  logic               act1,
   input  ctl_type            s2,
   input  ctl_type            s4,
   input  logic               act4,
   output logic signed [31:0] result
);

   logic signed [23:0] prod_ff;
   logic signed [15:0] bias_ff;
   logic signed [31:0] acc_ff;
   logic               pend_ff;
   shift_type          pshift_ff;
   logic signed [31:0] fin_ff;
   logic signed [31:0] bsh_ff;
   logic signed [31:0] al_ff;
   logic signed [31:0] b2_ff;
   logic signed [31:0] tot_ff;
   logic signed [31:0] res_ff;

   logic signed [31:0] base;
   logic signed [31:0] addend;
   logic signed [31:0] sum;

   always_comb begin
      base   = pend_ff ? sat_shift(acc_ff, pshift_ff) : acc_ff;
      addend = (s1.valid && act1) ? {{8{prod_ff[23]}}, prod_ff} : '0;
      sum    = base + addend;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= w * x;
         bias_ff <= bias;
      end
      pshift_ff <= s1.rescale_shift;
      fin_ff    <= sum;
      bsh_ff    <= align_bias(bias_ff, s1.bias_shift);
      al_ff     <= sat_shift(fin_ff, s2.align_shift);
      b2_ff     <= s2.bias_en ? bsh_ff : '0;
      tot_ff    <= al_ff + b2_ff;
      res_ff    <= act4 ? sat_shift(tot_ff, s4.out_shift) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= 1'b0;
      end else if (s1.valid && s1.is_final) begin
         acc_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         acc_ff  <= sum;
         pend_ff <= s1.valid && act1 && s1.rescale;
      end
   end

   assign result = res_ff;

   a_clear_after_final: assert property (@(posedge clock) disable iff (reset)
      (s1.valid && s1.is_final) |=> (acc_ff == '0 && !pend_ff))
      else $error("accumulator not cleared after a final beat");

endmodule

### rtl/core/qdl_merge.sv
// ----------------------------------------------------------------------------
// qdl_merge
// Collects the lane results of one final beat into a result beat and
// queues it in a small output FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdl_merge
   import qdl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic signed [31:0] lane_result [LANES],
   input  logic [2:0]         rows,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   rsp_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   rsp_type            entry;
   logic               pop;

   always_comb begin
      entry            = '0;
      entry.rows_valid = rows;
      for (int j = 0; j < LANES; j++) begin
         case (j)
            0: entry.result_0 = lane_result[j];
            1: entry.result_1 = lane_result[j];
            2: entry.result_2 = lane_result[j];
            3: entry.result_3 = lane_result[j];
            default: ;
         endcase
      end
   end

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(FIFO_DEPTH)))
      else $error("result FIFO written while full");

endmodule

### rtl/core/quantized_dense_layer_mac.sv
// ----------------------------------------------------------------------------
// quantized_dense_layer_mac
// A final beat passes the control stages s1 to s5 and is then written into
// the output FIFO, from which rsp_valid is driven. Throughput: one input
// beat per cycle while req_ready is high; four row lanes multiply in
// parallel. req_ready drops only while 8 results sit in flight or in the
// output FIFO. Reset (synchronous) clears accumulators, the FIFO and the
// pipeline, and returns all configuration registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quantized_dense_layer_mac
   import qdl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [2:0]       qk_ff;
   logic [3:0]       qin_ff;
   logic [3:0]       qrec_ff;
   logic [3:0]       qb_ff;
   logic             bias_en_ff;
   logic             rec_en_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   ctl_type          ctl_in;
   ctl_type          s1_ff;
   ctl_type          s2_in;
   ctl_type          s2_ff;
   ctl_type          s3_ff;
   ctl_type          s4_ff;
   ctl_type          s5_ff;

   logic               accept;
   logic               csr_write;
   logic [2:0]         reg_index;
   logic [3:0]         q;
   logic [4:0]         qprod;
   logic [4:0]         qs;
   logic [2:0]         rows;
   logic signed [7:0]  w_arr [LANES];
   logic signed [15:0] b_arr [LANES];
   logic signed [31:0] lane_result [LANES];

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         qk_ff      <= 3'd7;
         qin_ff     <= 4'd15;
         qrec_ff    <= 4'd15;
         qb_ff      <= 4'd15;
         bias_en_ff <= 1'b1;
         rec_en_ff  <= 1'b0;
      end else if (csr_write) begin
         case (reg_index)
            REG_KERNEL_FRAC: qk_ff      <= pwdata[2:0];
            REG_INPUT_FRAC:  qin_ff     <= pwdata[3:0];
            REG_REC_FRAC:    qrec_ff    <= pwdata[3:0];
            REG_BIAS_FRAC:   qb_ff      <= pwdata[3:0];
            REG_BIAS_EN:     bias_en_ff <= pwdata[0];
            REG_REC_EN:      rec_en_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_KERNEL_FRAC: prdata = {29'd0, qk_ff};
         REG_INPUT_FRAC:  prdata = {28'd0, qin_ff};
         REG_REC_FRAC:    prdata = {28'd0, qrec_ff};
         REG_BIAS_FRAC:   prdata = {28'd0, qb_ff};
         REG_BIAS_EN:     prdata = {31'd0, bias_en_ff};
         REG_REC_EN:      prdata = {31'd0, rec_en_ff};
         default:         prdata = '0;
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = (cnt_ff < CNT_W'(FIFO_DEPTH));

   always_comb begin
      q     = (rec_en_ff && req_data.phase_recurrent) ? qrec_ff : qin_ff;
      qprod = {1'b0, q} + {2'b0, qk_ff};
      qs    = (bias_en_ff && (qprod < 5'(OUT_SCALE))) ? 5'(OUT_SCALE) : qprod;
      if (req_data.rows_in_group == 3'd0) begin
         rows = 3'd1;
      end else if (req_data.rows_in_group > ROWS_MAX) begin
         rows = ROWS_MAX;
      end else begin
         rows = req_data.rows_in_group;
      end

      ctl_in          = '0;
      ctl_in.valid    = accept;
      ctl_in.is_final = req_data.last_element
                        && !(rec_en_ff && !req_data.phase_recurrent);
      ctl_in.rescale  = req_data.last_element && rec_en_ff && !req_data.phase_recurrent;
      for (int j = 0; j < LANES; j++) begin
         ctl_in.active[j] = (j < int'(rows));
      end
      ctl_in.rows          = rows;
      ctl_in.bias_en       = bias_en_ff;
      ctl_in.rescale_shift = {2'b0, qrec_ff} - {2'b0, qin_ff};
      ctl_in.bias_shift    = {1'b0, qs} - {2'b0, qb_ff};
      ctl_in.align_shift   = {1'b0, qs} - {1'b0, qprod};
      ctl_in.out_shift     = 6'(OUT_SCALE) - {1'b0, qs};
   end

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         case (j)
            0: begin
               w_arr[j] = req_data.weight_0;
               b_arr[j] = req_data.bias_0;
            end
            1: begin
               w_arr[j] = req_data.weight_1;
               b_arr[j] = req_data.bias_1;
            end
            2: begin
               w_arr[j] = req_data.weight_2;
               b_arr[j] = req_data.bias_2;
            end
            3: begin
               w_arr[j] = req_data.weight_3;
               b_arr[j] = req_data.bias_3;
            end
            default: begin
               w_arr[j] = '0;
               b_arr[j] = '0;
            end
         endcase
      end
   end

   always_comb begin
      s2_in       = s1_ff;
      s2_in.valid = s1_ff.valid && s1_ff.is_final;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
      end else begin
         s1_ff <= ctl_in;
         s2_ff <= s2_in;
         s3_ff <= s2_ff;
         s4_ff <= s3_ff;
         s5_ff <= s4_ff;
      end
   end

   always_comb begin
      cnt_in = cnt_ff + CNT_W'(accept && ctl_in.is_final) - CNT_W'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      qdl_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .load   (accept),
         .x      (req_data.in_value),
         .w      (w_arr[j]),
         .bias   (b_arr[j]),
         .s1     (s1_ff),
         .act1   (s1_ff.active[j]),
         .s2     (s2_ff),
         .s4     (s4_ff),
         .act4   (s4_ff.active[j]),
         .result (lane_result[j])
      );
   end

   qdl_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (s5_ff.valid),
      .lane_result (lane_result),
      .rows        (s5_ff.rows),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result credit count above FIFO depth");

   a_final_reaches_merge: assert property (@(posedge clock) disable iff (reset)
      (accept && ctl_in.is_final) |-> ##5 s5_ff.valid)
      else $error("final beat did not reach the merge stage");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cnt_ff != '0))
      else $error("result beat offered without a matching credit");

endmodule

### tb/quantized_dense_layer_mac_test.sv
// ----------------------------------------------------------------------------
// quantized_dense_layer_mac_test
// Self-checking testbench for the quantized dense layer MAC. A short table of
// directed beats and register writes runs first, then random layer vectors
// under many register settings. Every result beat is compared with a table
// entry or a local fixed-point row model, with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quantized_dense_layer_mac_test;
   import qdl_pkg::*;

   localparam int ITEMS       = 2000;
   localparam int QUIET_TAIL  = 200;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct {
      bit          is_cfg;
      logic [2:0]  reg_idx;
      int unsigned value;
      req_type     item;
      bit          typed;
      rsp_type     want;
   } dir_row_t;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   int      row_acc [LANES];
   int      cfg_qk, cfg_qin, cfg_qrec, cfg_qb, cfg_bias_en, cfg_rec;
   rsp_type pending_results [$];
   rsp_type want;
   dir_row_t dir_rows [$];

   int n_errors, n_beats, n_results, n_settings, rand_beats, cycle_count;
   int rx_hold;
   bit quiet, rx_calm, tx_calm;

   quantized_dense_layer_mac dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int sat_scale(input int x, input int s);
      longint v, hi, lo;
      if (s == 0) return x;
      if (s < 0) return x >>> ((-s > 31) ? 31 : -s);
      if (s > 31) s = 31;
      v  = x;
      hi = (longint'(1) << (31 - s)) - 1;
      lo = -(longint'(1) << (31 - s));
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return int'(v << s);
   endfunction

   function automatic bit dense_rows_step(input req_type d, output rsp_type r);
      int x, rows, q, qprod, qs, a, bv, bs;
      int w [4];
      int bias [4];
      int res [4];
      x = d.in_value;
      w[0] = d.weight_0;
      w[1] = d.weight_1;
      w[2] = d.weight_2;
      w[3] = d.weight_3;
      bias[0] = d.bias_0;
      bias[1] = d.bias_1;
      bias[2] = d.bias_2;
      bias[3] = d.bias_3;
      res = '{0, 0, 0, 0};
      r = '0;
      rows = d.rows_in_group;
      if (rows < 1) rows = 1;
      if (rows > int'(ROWS_MAX)) rows = int'(ROWS_MAX);
      for (int j = 0; j < rows; j++) row_acc[j] += w[j] * x;
      if (!d.last_element) return 1'b0;
      if (cfg_rec != 0 && !d.phase_recurrent) begin
         for (int j = 0; j < rows; j++) row_acc[j] = sat_scale(row_acc[j], cfg_qrec - cfg_qin);
         return 1'b0;
      end
      q = (cfg_rec != 0 && d.phase_recurrent) ? cfg_qrec : cfg_qin;
      qprod = q + cfg_qk;
      qs = qprod;
      if (cfg_bias_en != 0 && qs < OUT_SCALE) qs = OUT_SCALE;
      for (int j = 0; j < rows; j++) begin
         a = sat_scale(row_acc[j], qs - qprod);
         if (cfg_bias_en != 0) begin
            bv = bias[j];
            bs = qs - cfg_qb;
            if (bs >= 0) bv = bv << bs;
            else bv = bv >>> (-bs);
            a = a + bv;
         end
         res[j] = sat_scale(a, OUT_SCALE - qs);
      end
      r.result_0 = res[0];
      r.result_1 = res[1];
      r.result_2 = res[2];
      r.result_3 = res[3];
      r.rows_valid = 3'(rows);
      for (int j = 0; j < LANES; j++) row_acc[j] = 0;
      return 1'b1;
   endfunction

   function automatic req_type pack_req(input int x, input int w0, input int w1, input int w2,
                                        input int w3, input int b0, input int b1, input int b2,
                                        input int b3, input int rows, input bit ph,
                                        input bit last);
      req_type r;
      r.in_value        = 16'(x);
      r.weight_0        = 8'(w0);
      r.weight_1        = 8'(w1);
      r.weight_2        = 8'(w2);
      r.weight_3        = 8'(w3);
      r.bias_0          = 16'(b0);
      r.bias_1          = 16'(b1);
      r.bias_2          = 16'(b2);
      r.bias_3          = 16'(b3);
      r.rows_in_group   = 3'(rows);
      r.phase_recurrent = ph;
      r.last_element    = last;
      return r;
   endfunction

   function automatic rsp_type pack_rsp(input int r0, input int r1, input int r2, input int r3,
                                        input int rows);
      rsp_type r;
      r.result_0   = r0;
      r.result_1   = r1;
      r.result_2   = r2;
      r.result_3   = r3;
      r.rows_valid = 3'(rows);
      return r;
   endfunction

   function automatic dir_row_t cfg_row(input logic [2:0] idx, input int unsigned val);
      dir_row_t e;
      e.is_cfg  = 1'b1;
      e.reg_idx = idx;
      e.value   = val;
      e.item    = '0;
      e.typed   = 1'b0;
      e.want    = '0;
      return e;
   endfunction

   function automatic dir_row_t beat_row(input req_type d, input bit typed, input rsp_type w);
      dir_row_t e;
      e.is_cfg  = 1'b0;
      e.reg_idx = REG_KERNEL_FRAC;
      e.value   = 0;
      e.item    = d;
      e.typed   = typed;
      e.want    = w;
      return e;
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick8();
      case ($urandom_range(0, 9))
         0: return 8'h80;
         1: return 8'h7F;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic check_field(input string name, input longint exp_v, input longint got_v);
      if (exp_v != got_v) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (pending_results.size() == 0) begin
            n_errors++;
            $display("%0t: result beat with nothing expected, actual rows_valid %0d",
                     $time, rsp_data.rows_valid);
         end else begin
            want = pending_results.pop_front();
            check_field("result_0", want.result_0, rsp_data.result_0);
            check_field("result_1", want.result_1, rsp_data.result_1);
            check_field("result_2", want.result_2, rsp_data.result_2);
            check_field("result_3", want.result_3, rsp_data.result_3);
            check_field("rows_valid", want.rows_valid, rsp_data.rows_valid);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_ready <= 1'b0;
      end else if (!quiet && !rx_calm && $urandom_range(0, 4) == 0) begin
         rx_hold = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) rx_calm = !rx_calm;
   end

   task automatic send_beat(input req_type d, input bit typed, input rsp_type w);
      rsp_type r;
      if (!quiet && !tx_calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      if (dense_rows_step(d, r)) pending_results.push_back(typed ? w : r);
      n_beats++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input int unsigned val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_KERNEL_FRAC: cfg_qk      = val & 7;
         REG_INPUT_FRAC:  cfg_qin     = val & 15;
         REG_REC_FRAC:    cfg_qrec    = val & 15;
         REG_BIAS_FRAC:   cfg_qb      = val & 15;
         REG_BIAS_EN:     cfg_bias_en = val & 1;
         REG_REC_EN:      cfg_rec     = val & 1;
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_layer();
      int rows, n_len;
      bit noisy;
      req_type d;
      rows  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      noisy = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
      for (int ph = 0; ph < ((cfg_rec != 0) ? 2 : 1); ph++) begin
         n_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 32) : $urandom_range(1, 6);
         for (int i = 0; i < n_len; i++) begin
            d.in_value        = pick16();
            d.weight_0        = pick8();
            d.weight_1        = pick8();
            d.weight_2        = pick8();
            d.weight_3        = pick8();
            d.bias_0          = pick16();
            d.bias_1          = pick16();
            d.bias_2          = pick16();
            d.bias_3          = pick16();
            d.rows_in_group   = 3'(rows);
            d.phase_recurrent = (cfg_rec != 0) ? ph[0] : 1'($urandom);
            d.last_element    = (i == n_len - 1);
            if (noisy) begin
               d.rows_in_group   = 3'($urandom);
               d.phase_recurrent = 1'($urandom);
               d.last_element    = ($urandom_range(0, 3) == 0);
            end
            quiet = (rand_beats >= ITEMS - QUIET_TAIL);
            send_beat(d, 1'b0, '0);
            rand_beats++;
         end
      end
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      cfg_qk      = 7;
      cfg_qin     = 15;
      cfg_qrec    = 15;
      cfg_qb      = 15;
      cfg_bias_en = 1;
      cfg_rec     = 0;
      for (int j = 0; j < LANES; j++) row_acc[j] = 0;

      // Reset settings: product scale 22, so results are the sums shifted right by 7.
      dir_rows.push_back(beat_row(pack_req(-32768, -128, -128, -128, -128, 0, 0, 0, 0, 4, 0, 1),
                                  1'b1, pack_rsp(32768, 32768, 32768, 32768, 4)));
      dir_rows.push_back(beat_row(pack_req(-32768, 127, -128, -128, -128, 0, -32768, 32767, -1,
                                           1, 0, 1), 1'b1, pack_rsp(-32512, 0, 0, 0, 1)));
      dir_rows.push_back(beat_row(pack_req(0, 0, 55, -3, 9, -32768, 0, 0, 0, 0, 0, 1),
                                  1'b1, pack_rsp(-32768, 0, 0, 0, 1)));
      dir_rows.push_back(beat_row(pack_req(0, 0, 0, 0, 0, 32767, 32767, 32767, 32767, 7, 1, 1),
                                  1'b1, pack_rsp(32767, 32767, 32767, 32767, 4)));
      dir_rows.push_back(beat_row(pack_req(32767, 127, -128, 1, -1, 0, 0, 0, 0, 4, 0, 0),
                                  1'b0, '0));
      dir_rows.push_back(beat_row(pack_req(-1, 127, 127, 127, 127, 0, 0, 0, 0, 2, 0, 0),
                                  1'b0, '0));
      dir_rows.push_back(beat_row(pack_req(-32768, -128, 127, -128, 127, -32768, 32767, -32768,
                                           32767, 4, 0, 1), 1'b0, '0));
      dir_rows.push_back(cfg_row(REG_BIAS_EN, 0));
      dir_rows.push_back(beat_row(pack_req(-32768, -128, -128, -128, -128, 0, 0, 0, 0, 3, 0, 1),
                                  1'b0, '0));
      dir_rows.push_back(cfg_row(REG_KERNEL_FRAC, 0));
      dir_rows.push_back(cfg_row(REG_INPUT_FRAC, 0));
      // Scale zero without bias: the output shift of 15 saturates both ways.
      dir_rows.push_back(beat_row(pack_req(32767, 127, 127, 127, 127, 0, 0, 0, 0, 4, 0, 1),
                                  1'b1, pack_rsp(32'sh7FFF_8000, 32'sh7FFF_8000, 32'sh7FFF_8000,
                                                 32'sh7FFF_8000, 4)));
      dir_rows.push_back(beat_row(pack_req(-32768, 127, 127, 127, 127, 0, 0, 0, 0, 4, 0, 1),
                                  1'b1, pack_rsp(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                                 32'sh8000_0000, 4)));
      dir_rows.push_back(cfg_row(REG_BIAS_EN, 1));
      dir_rows.push_back(cfg_row(REG_BIAS_FRAC, 0));
      dir_rows.push_back(beat_row(pack_req(-32768, -128, 127, 1, 0, -32768, 32767, -1, 1, 4, 0, 1),
                                  1'b0, '0));
      dir_rows.push_back(cfg_row(REG_REC_FRAC, 0));
      dir_rows.push_back(cfg_row(REG_INPUT_FRAC, 15));
      dir_rows.push_back(cfg_row(REG_KERNEL_FRAC, 7));
      dir_rows.push_back(cfg_row(REG_BIAS_FRAC, 15));
      dir_rows.push_back(cfg_row(REG_REC_EN, 1));
      dir_rows.push_back(beat_row(pack_req(32767, 127, -128, 5, -5, 0, 0, 0, 0, 4, 0, 0),
                                  1'b0, '0));
      dir_rows.push_back(beat_row(pack_req(32767, 127, -128, 5, -5, 0, 0, 0, 0, 4, 0, 1),
                                  1'b0, '0));
      dir_rows.push_back(beat_row(pack_req(-32768, 1, 2, 3, 4, 100, -100, 32767, -32768, 4, 1, 1),
                                  1'b0, '0));
      dir_rows.push_back(cfg_row(REG_REC_FRAC, 15));
      dir_rows.push_back(cfg_row(REG_INPUT_FRAC, 0));
      dir_rows.push_back(beat_row(pack_req(-32768, 127, -128, 127, -128, 0, 0, 0, 0, 4, 0, 1),
                                  1'b0, '0));
      dir_rows.push_back(beat_row(pack_req(3, -1, -1, -1, -1, 5, 6, 7, 8, 2, 1, 1), 1'b0, '0));
      dir_rows.push_back(beat_row(pack_req(1, 1, 1, 1, 1, 0, 0, 0, 0, 4, 1, 1), 1'b0, '0));
      dir_rows.push_back(beat_row(pack_req(-7, 3, 3, 3, 3, 0, 0, 0, 0, 3, 1, 0), 1'b0, '0));
      dir_rows.push_back(beat_row(pack_req(-7, 3, 3, 3, 3, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0));
      dir_rows.push_back(beat_row(pack_req(9, -9, 9, -9, 9, -1, 1, -1, 1, 4, 1, 1), 1'b0, '0));

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            wait_idle();
            csr_write(dir_rows[i].reg_idx, dir_rows[i].value);
         end else begin
            send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      while (rand_beats < ITEMS) begin
         wait_idle();
         case (n_settings)
            0: begin
               csr_write(REG_KERNEL_FRAC, 0);
               csr_write(REG_INPUT_FRAC, 0);
               csr_write(REG_REC_FRAC, 0);
               csr_write(REG_BIAS_FRAC, 0);
               csr_write(REG_BIAS_EN, 0);
               csr_write(REG_REC_EN, 0);
            end
            1: begin
               csr_write(REG_KERNEL_FRAC, 7);
               csr_write(REG_INPUT_FRAC, 15);
               csr_write(REG_REC_FRAC, 15);
               csr_write(REG_BIAS_FRAC, 15);
               csr_write(REG_BIAS_EN, 1);
               csr_write(REG_REC_EN, 1);
            end
            default: begin
               csr_write(REG_KERNEL_FRAC, $urandom_range(0, 7));
               csr_write(REG_INPUT_FRAC, $urandom_range(0, 15));
               csr_write(REG_REC_FRAC, $urandom_range(0, 15));
               csr_write(REG_BIAS_FRAC, $urandom_range(0, 15));
               csr_write(REG_BIAS_EN, ($urandom_range(0, 3) != 0));
               csr_write(REG_REC_EN, $urandom_range(0, 1));
            end
         endcase
         n_settings++;
         repeat ($urandom_range(8, 16)) begin
            if (rand_beats >= ITEMS) break;
            send_layer();
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Sent %0d input beats (%0d random) and checked %0d result beats,",
               n_beats, rand_beats, n_results);
      $display("across %0d random register settings plus the directed table.", n_settings);
      if (n_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/qdl_pkg.sv
rtl/core/qdl_lane.sv
rtl/core/qdl_merge.sv
rtl/core/quantized_dense_layer_mac.sv
tb/quantized_dense_layer_mac_test.sv
